### rtl/mmas_pkg.sv
// constants and sizing shared by the moving average scaler
package mmas_pkg;

  // block sizing
  localparam int CHANNELS    = 4;
  localparam int WINDOW      = 20;
  localparam int SAMPLE_BITS = 10;

  // fixed field widths
  localparam int CHAN_BITS      = 2;
  localparam int GAIN_BITS      = 16;
  localparam int OFFSET_BITS    = 20;
  localparam int SCALED_BITS    = 27;
  localparam int CFG_DATA_BITS  = 20;
  localparam int CFG_INDEX_BITS = 1;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN   = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET = 1'd1;

  // register reset values (0.02597 and 2.88312 in units of 2^-16)
  localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 16'd1702;
  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 20'd188948;

  // derived sizes
  localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_BITS    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SLOTS       = CHANNELS * WINDOW;
  localparam int SLOT_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_MAX     = WINDOW * ((1 << SAMPLE_BITS) - 1);
  localparam int SUM_BITS    = $clog2(SUM_MAX + 1);

  // exact division by WINDOW through a scaled reciprocal
  localparam int WIN_LOG     = $clog2(WINDOW);
  localparam int RECIP_SHIFT = SUM_BITS + WIN_LOG;
  localparam int RECIP_BITS  = SUM_BITS + 1;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

  // width of the scaling arithmetic
  localparam int MATH_BITS = (SAMPLE_BITS + GAIN_BITS > SCALED_BITS) ?
                             (SAMPLE_BITS + GAIN_BITS) : SCALED_BITS;

endpackage

### rtl/multichannel_moving_average_scaler.sv
// multichannel boxcar moving average with linear fixed-point scaling
//
// usage:
//   input channel (in_valid_i / in_ready_o) carries one converter request:
//   a channel number and a raw sample. each channel keeps a ring of the
//   last WINDOW samples in one shared sample memory plus a running sum.
//   output channel (out_valid_o / out_ready_i) returns exactly one result
//   per request, in order: the channel, the truncated window mean and
//   mean * gain - offset as a signed value in units of 2^-16.
//   gain and offset are set through the write port (cfg_we_i) while idle.
// throughput:
//   a request is accepted every cycle while stage 1 has room; the rate is
//   set by the sample memory port: one read-first access per cycle reads
//   the oldest sample and stores the new one in the same slot.
// reset:
//   pointers, sums and per-slot valid bits clear at once; a slot never
//   written reads as zero, so early means include the reset zeros.
//   gain and offset return to their default values.
// stall:
//   when the receiver holds out_ready_i low, the four stages fill up and
//   in_ready_o drops only once no stage has room left.
module multichannel_moving_average_scaler (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration write port
  input  logic                                    cfg_we_i,
  input  logic [mmas_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [mmas_pkg::CFG_DATA_BITS-1:0]      cfg_wdata_i,
  // sample requests
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [mmas_pkg::CHAN_BITS-1:0]          channel_i,
  input  logic [mmas_pkg::SAMPLE_BITS-1:0]        sample_i,
  // results
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [mmas_pkg::CHAN_BITS-1:0]          out_channel_o,
  output logic [mmas_pkg::SAMPLE_BITS-1:0]        average_o,
  output logic signed [mmas_pkg::SCALED_BITS-1:0] scaled_o
);

  // configuration registers
  logic [mmas_pkg::GAIN_BITS-1:0]   gain_q;
  logic [mmas_pkg::OFFSET_BITS-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= mmas_pkg::GAIN_RESET;
      offset_q <= mmas_pkg::OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mmas_pkg::REG_GAIN:   gain_q   <= cfg_wdata_i[mmas_pkg::GAIN_BITS-1:0];
        mmas_pkg::REG_OFFSET: offset_q <= cfg_wdata_i[mmas_pkg::OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy and flow control
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic out_free, s3_free, s2_free, s1_free;
  logic in_fire, s1_go;

  // a stage has room when empty or when it moves on this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign s3_free    = !s3_valid_q || out_free;
  assign s2_free    = !s2_valid_q || s3_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;
  assign in_fire    = in_valid_i && s1_free;
  assign s1_go      = s1_valid_q && s2_free;

  // channel number reduced modulo the channel count
  logic [mmas_pkg::CHAN_BITS-1:0]   ch_rem;
  logic [mmas_pkg::CH_IDX_BITS-1:0] ch_idx;

  always_comb begin
    ch_rem = channel_i;
    for (int i = 0; i < (1 << mmas_pkg::CHAN_BITS) - 1; i++) begin
      if (ch_rem >= mmas_pkg::CHANNELS) begin
        ch_rem = ch_rem - mmas_pkg::CHAN_BITS'(mmas_pkg::CHANNELS);
      end
    end
  end

  assign ch_idx = mmas_pkg::CH_IDX_BITS'(ch_rem);

  // per-channel write pointers
  logic [mmas_pkg::PTR_BITS-1:0]  wptr_q [mmas_pkg::CHANNELS];
  logic [mmas_pkg::PTR_BITS-1:0]  cur_ptr, next_ptr;
  logic [mmas_pkg::SLOT_BITS-1:0] slot;

  assign cur_ptr  = wptr_q[ch_idx];
  assign next_ptr = (cur_ptr == mmas_pkg::PTR_BITS'(mmas_pkg::WINDOW - 1)) ?
                    '0 : cur_ptr + 1'b1;
  // ring base of the channel plus the pointer
  assign slot = mmas_pkg::SLOT_BITS'(ch_idx) * mmas_pkg::SLOT_BITS'(mmas_pkg::WINDOW)
              + mmas_pkg::SLOT_BITS'(cur_ptr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < mmas_pkg::CHANNELS; c++) begin
        wptr_q[c] <= '0;
      end
    end else if (in_fire) begin
      wptr_q[ch_idx] <= next_ptr;
    end
  end

  // sample memory, read-first: the old sample comes out as the new one goes in
  logic [mmas_pkg::SAMPLE_BITS-1:0] ring_mem [mmas_pkg::SLOTS];
  logic [mmas_pkg::SAMPLE_BITS-1:0] ring_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ring_rd_q      <= ring_mem[slot];
      ring_mem[slot] <= sample_i;
    end
  end

  // slot valid bits stand in for the cleared ring after reset
  logic [mmas_pkg::SLOTS-1:0] slot_vld_q;
  logic                       ring_rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q    <= '0;
      ring_rd_vld_q <= 1'b0;
    end else if (in_fire) begin
      slot_vld_q[slot] <= 1'b1;
      ring_rd_vld_q    <= slot_vld_q[slot];
    end
  end

  // stage 1: request held while the memory read completes
  logic [mmas_pkg::CH_IDX_BITS-1:0] s1_ch_q;
  logic [mmas_pkg::SAMPLE_BITS-1:0] s1_smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q  <= ch_idx;
      s1_smp_q <= sample_i;
    end
  end

  // running window sums, updated as the request leaves stage 1
  logic [mmas_pkg::SUM_BITS-1:0]    sum_q [mmas_pkg::CHANNELS];
  logic [mmas_pkg::SAMPLE_BITS-1:0] old_smp;
  logic [mmas_pkg::SUM_BITS-1:0]    sum_d;

  assign old_smp = ring_rd_vld_q ? ring_rd_q : '0;
  assign sum_d   = sum_q[s1_ch_q] - mmas_pkg::SUM_BITS'(old_smp)
                 + mmas_pkg::SUM_BITS'(s1_smp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < mmas_pkg::CHANNELS; c++) begin
        sum_q[c] <= '0;
      end
    end else if (s1_go) begin
      sum_q[s1_ch_q] <= sum_d;
    end
  end

  // stage 2: new window sum
  logic [mmas_pkg::CH_IDX_BITS-1:0] s2_ch_q;
  logic [mmas_pkg::SUM_BITS-1:0]    s2_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_ch_q  <= s1_ch_q;
      s2_sum_q <= sum_d;
    end
  end

  // mean through the reciprocal of the window length, exact over the sum range
  logic [mmas_pkg::PROD_BITS-1:0]   recip_prod;
  logic [mmas_pkg::SAMPLE_BITS-1:0] avg_d;

  assign recip_prod = mmas_pkg::PROD_BITS'(s2_sum_q) * mmas_pkg::PROD_BITS'(mmas_pkg::RECIP);
  assign avg_d      = recip_prod[mmas_pkg::RECIP_SHIFT +: mmas_pkg::SAMPLE_BITS];

  // stage 3: mean
  logic [mmas_pkg::CH_IDX_BITS-1:0] s3_ch_q;
  logic [mmas_pkg::SAMPLE_BITS-1:0] s3_avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_free) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_free) begin
      s3_ch_q  <= s2_ch_q;
      s3_avg_q <= avg_d;
    end
  end

  // linear scaling: mean * gain - offset, kept to the low result bits
  logic [mmas_pkg::MATH_BITS-1:0] scale_math;

  assign scale_math = mmas_pkg::MATH_BITS'(s3_avg_q) * mmas_pkg::MATH_BITS'(gain_q)
                    - mmas_pkg::MATH_BITS'(offset_q);

  // output register
  logic [mmas_pkg::CH_IDX_BITS-1:0]        out_ch_q;
  logic [mmas_pkg::SAMPLE_BITS-1:0]        out_avg_q;
  logic signed [mmas_pkg::SCALED_BITS-1:0] out_scaled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q && out_free) begin
      out_ch_q     <= s3_ch_q;
      out_avg_q    <= s3_avg_q;
      out_scaled_q <= $signed(scale_math[mmas_pkg::SCALED_BITS-1:0]);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = mmas_pkg::CHAN_BITS'(out_ch_q);
  assign average_o     = out_avg_q;
  assign scaled_o      = out_scaled_q;

  // a window sum never exceeds a full window of maximum samples
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_sum_q <= mmas_pkg::SUM_BITS'(mmas_pkg::SUM_MAX)))
    else $error("window sum out of range");

  // the pointer of an accepted channel stays inside its ring
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (cur_ptr <= mmas_pkg::PTR_BITS'(mmas_pkg::WINDOW - 1)))
    else $error("write pointer out of range");

  // an accepted request always lands in stage 1 on the next cycle
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted request lost at stage 1");

  // a full pipeline with a stalled receiver takes no request
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q && !out_ready_i)
      |-> !in_ready_o)
    else $error("request taken while pipeline full");

endmodule
